[design/nla_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest landmark association package
// Shared field widths, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package nla_pkg;

  // Field widths of the input and result beats.
  localparam int COORD_W    = 24;
  localparam int LABEL_W    = 16;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int SLOT_OUT_W = 6;
  localparam int CMD_W      = 2;

  // One stored table entry: label, y and x packed together.
  localparam int ENTRY_W    = LABEL_W + 2 * COORD_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Result status codes.
  localparam logic STATUS_MATCH = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Query sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

[design/nearest_landmark_association_core.sv]
// Clear and append beats are taken in ST_IDLE, so the input stays ready after them.
// A query over N stored landmarks is scanned in ST_SCAN, where one table read
// per cycle feeds a three-stage distance pipeline; ST_DRAIN empties it and ST_DONE
// loads the result. New beats are stalled until then; an empty table skips the scan.
// The result register lets the next beat be taken while a result waits.
// Synchronous active-low reset empties the table and drops any pending result.
// ----------------------------------------------------------------------------
// Nearest landmark association core
// Landmark table with clear, append and nearest-neighbour query commands.
// ----------------------------------------------------------------------------
module nearest_landmark_association_core
  import nla_pkg::*;
#(
  parameter int MAX_LANDMARKS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CMD_W-1:0]          in_command,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic [LABEL_W-1:0]        in_landmark_label,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [LABEL_W-1:0]        out_match_label,
  output logic [SLOT_OUT_W-1:0]     out_match_slot,
  output logic [DIST_W-1:0]         out_nearest_distance_sq,
  output logic                      out_status
);

  localparam int SLOT_W = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int CNT_W  = $clog2(MAX_LANDMARKS + 1);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   scan_idx_r, scan_idx_nxt;
  logic [COORD_W-1:0] query_x_r, query_y_r;

  logic [ENTRY_W-1:0] table_mem [MAX_LANDMARKS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               rd_vld_r;
  logic [SLOT_W-1:0]  rd_slot_r;

  logic               dist_vld, dist_busy;
  logic [DIST_W-1:0]  dist_val;
  logic [LABEL_W-1:0] dist_label;
  logic [SLOT_W-1:0]  dist_slot;

  logic               best_found_r;
  logic [DIST_W-1:0]  best_dist_r;
  logic [LABEL_W-1:0] best_label_r;
  logic [SLOT_W-1:0]  best_slot_r;
  logic               best_take;

  logic               out_valid_r;
  logic [LABEL_W-1:0] out_label_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_status_r;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  logic accept, do_append, do_query, scan_rd, scan_last, out_free, out_load;

  // Beat acceptance and command decode.
  assign accept    = in_valid & ~in_stall;
  assign do_append = accept & (in_command == CMD_APPEND) &
                     (count_r < CNT_W'(MAX_LANDMARKS));
  assign do_query  = accept & (in_command == CMD_QUERY);
  assign scan_last = (scan_idx_r == count_r - CNT_W'(1));
  assign out_free  = ~out_valid_r | ~out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (do_query) begin
          state_nxt = (count_r == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !dist_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = 1'b1;
    scan_rd  = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  scan_rd  = 1'b1;
      ST_DRAIN: in_stall = 1'b1;
      ST_DONE:  out_load = out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  // Entry count and scan index.
  always_comb begin
    count_nxt    = count_r;
    scan_idx_nxt = scan_idx_r;
    if (accept && in_command == CMD_CLEAR) begin
      count_nxt = '0;
    end else if (do_append) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (do_query) begin
      scan_idx_nxt = '0;
    end else if (scan_rd) begin
      scan_idx_nxt = scan_idx_r + CNT_W'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      scan_idx_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      scan_idx_r <= scan_idx_nxt;
      rd_vld_r   <= scan_rd;
    end
  end

  // Query point is held for the whole scan.
  always_ff @(posedge clk) begin
    if (do_query) begin
      query_x_r <= in_coord_x;
      query_y_r <= in_coord_y;
    end
  end

  // Landmark table: one write port for appends, one registered read port.
  always_ff @(posedge clk) begin
    if (do_append) begin
      table_mem[count_r[SLOT_W-1:0]] <= {in_landmark_label, in_coord_y, in_coord_x};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= table_mem[scan_idx_r[SLOT_W-1:0]];
    rd_slot_r <= scan_idx_r[SLOT_W-1:0];
  end

  // Shared distance pipeline.
  nla_dist_unit #(
    .SLOT_W (SLOT_W)
  ) u_dist (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (rd_vld_r),
    .query_x     (query_x_r),
    .query_y     (query_y_r),
    .entry_x     (rd_data_r[COORD_W-1:0]),
    .entry_y     (rd_data_r[2*COORD_W-1:COORD_W]),
    .entry_label (rd_data_r[ENTRY_W-1:2*COORD_W]),
    .entry_slot  (rd_slot_r),
    .out_vld     (dist_vld),
    .out_dist    (dist_val),
    .out_label   (dist_label),
    .out_slot    (dist_slot),
    .busy        (dist_busy)
  );

  // Running minimum; a strict compare keeps the earliest entry on a tie.
  assign best_take = dist_vld & (~best_found_r | (dist_val < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (do_query) begin
      best_found_r <= 1'b0;
    end else if (dist_vld) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (best_take) begin
      best_dist_r  <= dist_val;
      best_label_r <= dist_label;
      best_slot_r  <= dist_slot;
    end
  end

  // Result register.
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, best_slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (best_found_r) begin
        out_label_r  <= best_label_r;
        out_slot_r   <= slot_ext[SLOT_OUT_W-1:0];
        out_dist_r   <= best_dist_r;
        out_status_r <= STATUS_MATCH;
      end else begin
        out_label_r  <= '0;
        out_slot_r   <= '0;
        out_dist_r   <= '0;
        out_status_r <= STATUS_EMPTY;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_match_label         = out_label_r;
  assign out_match_slot          = out_slot_r;
  assign out_nearest_distance_sq = out_dist_r;
  assign out_status              = out_status_r;

endmodule

[design/nla_dist_unit.sv]
// ----------------------------------------------------------------------------
// Nearest landmark association distance unit
// Three-stage pipeline computing the squared Euclidean distance between the
// query point and one table entry per cycle; label and slot ride alongside.
// ----------------------------------------------------------------------------
module nla_dist_unit
  import nla_pkg::*;
#(
  parameter int SLOT_W = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [COORD_W-1:0] query_x,
  input  logic [COORD_W-1:0] query_y,
  input  logic [COORD_W-1:0] entry_x,
  input  logic [COORD_W-1:0] entry_y,
  input  logic [LABEL_W-1:0] entry_label,
  input  logic [SLOT_W-1:0]  entry_slot,
  output logic               out_vld,
  output logic [DIST_W-1:0]  out_dist,
  output logic [LABEL_W-1:0] out_label,
  output logic [SLOT_W-1:0]  out_slot,
  output logic               busy
);

  logic               s1_vld_r, s2_vld_r, s3_vld_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]    sqx_r, sqy_r;
  logic [DIST_W-1:0]  dist_r;
  logic [LABEL_W-1:0] s1_label_r, s2_label_r, s3_label_r;
  logic [SLOT_W-1:0]  s1_slot_r, s2_slot_r, s3_slot_r;

  logic [COORD_W:0]   diff_x, diff_y, neg_x, neg_y;
  logic [COORD_W-1:0] dx_nxt, dy_nxt;

  // Absolute coordinate differences; the magnitude always fits in COORD_W bits.
  always_comb begin
    diff_x = {query_x[COORD_W-1], query_x} - {entry_x[COORD_W-1], entry_x};
    diff_y = {query_y[COORD_W-1], query_y} - {entry_y[COORD_W-1], entry_y};
    neg_x  = (COORD_W+1)'(0) - diff_x;
    neg_y  = (COORD_W+1)'(0) - diff_y;
    dx_nxt = diff_x[COORD_W] ? neg_x[COORD_W-1:0] : diff_x[COORD_W-1:0];
    dy_nxt = diff_y[COORD_W] ? neg_y[COORD_W-1:0] : diff_y[COORD_W-1:0];
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Datapath: difference, square, sum.
  always_ff @(posedge clk) begin
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    s1_label_r <= entry_label;
    s1_slot_r  <= entry_slot;

    sqx_r      <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r      <= SQ_W'(dy_r) * SQ_W'(dy_r);
    s2_label_r <= s1_label_r;
    s2_slot_r  <= s1_slot_r;

    dist_r     <= DIST_W'(sqx_r) + DIST_W'(sqy_r);
    s3_label_r <= s2_label_r;
    s3_slot_r  <= s2_slot_r;
  end

  assign out_vld   = s3_vld_r;
  assign out_dist  = dist_r;
  assign out_label = s3_label_r;
  assign out_slot  = s3_slot_r;
  assign busy      = s1_vld_r | s2_vld_r | s3_vld_r;

endmodule
